/* src/pps_pkg.sv */
// Shared types, constants and the multiply-accumulate program of the
// polyline simplifier. Used by pps_ctrl, pps_datapath and the top level.
package pps_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int TOL_W           = 23;
    localparam int DEG_W           = 12;
    localparam int DEG_SQ_W        = 2 * DEG_W;
    localparam int CFG_DATA_W      = 23;
    localparam int CFG_IDX_W       = 1;

    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(2048);
    localparam logic [DEG_SQ_W-1:0] DEG_SQ_RESET = DEG_SQ_W'(16);

    localparam int STEP_W   = 5;
    localparam int PROG_LEN = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE  = 1'b0,
        CFG_DEGEN_LEN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIFF,
        ST_RUN,
        ST_FLUSH,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // Multiplier operand sources
    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_A0, SRC_A1, SRC_A2,
        SRC_B0, SRC_B1, SRC_B2,
        SRC_CLO, SRC_CHI,
        SRC_TOL,
        SRC_BB0, SRC_BB1,
        SRC_TB0, SRC_TB1, SRC_TB2
    } src_t;

    // Accumulator targets
    typedef enum logic [2:0] {
        DST_NONE,
        DST_BB,
        DST_XNEW,
        DST_XSUB,
        DST_CC,
        DST_TB,
        DST_RHS
    } dst_t;

    // Product alignment: none, one chunk, one chunk plus one bit, two chunks
    typedef enum logic [1:0] {
        SH_0,
        SH_1,
        SH_1P,
        SH_2
    } shift_t;

    typedef enum logic {
        OUT_NEW,
        OUT_PEND
    } out_sel_t;

    typedef struct packed {
        src_t   src_a;
        src_t   src_b;
        dst_t   dst;
        shift_t sh;
    } mac_step_t;

    typedef struct packed {
        logic      load_in;
        logic      load_diff;
        logic      out_load;
        out_sel_t  out_sel;
        logic      out_last;
        logic      anchor_from_new;
        logic      anchor_from_pend;
        logic      pend_from_new;
        mac_step_t step;
    } ctl_cmd_t;

    localparam mac_step_t STEP_NOP = '{SRC_NONE, SRC_NONE, DST_NONE, SH_0};

    // |b|^2, the three cross components with their squares, and
    // tol * (tol * |b|^2), interleaved so no step reads a value still in flight.
    function automatic mac_step_t prog_step(input logic [STEP_W-1:0] idx);
        mac_step_t s;
        s = STEP_NOP;
        case (idx)
            5'd0:  s = '{SRC_B0,  SRC_B0,  DST_BB,   SH_0};
            5'd1:  s = '{SRC_B1,  SRC_B1,  DST_BB,   SH_0};
            5'd2:  s = '{SRC_B2,  SRC_B2,  DST_BB,   SH_0};
            5'd3:  s = '{SRC_A1,  SRC_B2,  DST_XNEW, SH_0};
            5'd4:  s = '{SRC_A2,  SRC_B1,  DST_XSUB, SH_0};
            5'd5:  s = '{SRC_TOL, SRC_BB0, DST_TB,   SH_0};
            5'd6:  s = '{SRC_CLO, SRC_CLO, DST_CC,   SH_0};
            5'd7:  s = '{SRC_CLO, SRC_CHI, DST_CC,   SH_1P};
            5'd8:  s = '{SRC_CHI, SRC_CHI, DST_CC,   SH_2};
            5'd9:  s = '{SRC_A2,  SRC_B0,  DST_XNEW, SH_0};
            5'd10: s = '{SRC_A0,  SRC_B2,  DST_XSUB, SH_0};
            5'd11: s = '{SRC_TOL, SRC_BB1, DST_TB,   SH_1};
            5'd12: s = '{SRC_CLO, SRC_CLO, DST_CC,   SH_0};
            5'd13: s = '{SRC_CLO, SRC_CHI, DST_CC,   SH_1P};
            5'd14: s = '{SRC_CHI, SRC_CHI, DST_CC,   SH_2};
            5'd15: s = '{SRC_A0,  SRC_B1,  DST_XNEW, SH_0};
            5'd16: s = '{SRC_A1,  SRC_B0,  DST_XSUB, SH_0};
            5'd17: s = '{SRC_TOL, SRC_TB0, DST_RHS,  SH_0};
            5'd18: s = '{SRC_CLO, SRC_CLO, DST_CC,   SH_0};
            5'd19: s = '{SRC_CLO, SRC_CHI, DST_CC,   SH_1P};
            5'd20: s = '{SRC_CHI, SRC_CHI, DST_CC,   SH_2};
            5'd21: s = '{SRC_TOL, SRC_TB1, DST_RHS,  SH_1};
            5'd22: s = '{SRC_TOL, SRC_TB2, DST_RHS,  SH_2};
            default: s = STEP_NOP;
        endcase
        return s;
    endfunction

endpackage

/* src/pps_ctrl.sv */
// Controller of the polyline simplifier: path flags, program sequencing and
// output word handshake. Depends on pps_pkg; drives pps_datapath by command.
module pps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_final_point,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              keep,
    output pps_pkg::ctl_cmd_t cmd
);
    import pps_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              started_reg, started_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              fin_reg, fin_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            started_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            fin_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            started_reg    <= started_next;
            pend_valid_reg <= pend_valid_next;
            fin_reg        <= fin_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        started_next    = started_reg;
        pend_valid_next = pend_valid_reg;
        fin_next        = fin_reg;
        s_ready         = 1'b0;
        cmd             = '{load_in: 1'b0, load_diff: 1'b0, out_load: 1'b0,
                            out_sel: OUT_NEW, out_last: 1'b0,
                            anchor_from_new: 1'b0, anchor_from_pend: 1'b0,
                            pend_from_new: 1'b0, step: STEP_NOP};

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    fin_next    = s_final_point;
                    if (!started_reg) begin
                        state_next = ST_START;
                    end else if (pend_valid_reg) begin
                        state_next = ST_DIFF;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_START: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_NEW;
                    cmd.out_last = fin_reg;
                    if (!fin_reg) begin
                        cmd.anchor_from_new = 1'b1;
                        started_next        = 1'b1;
                        pend_valid_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_DIFF: begin
                cmd.load_diff = 1'b1;
                step_next     = '0;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                cmd.step = prog_step(step_reg);
                if (step_reg == STEP_W'(PROG_LEN - 1)) begin
                    state_next = ST_FLUSH;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FLUSH: begin
                // last product lands in its accumulator this cycle
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!keep) begin
                    state_next = ST_FINISH;
                end else if (out_free) begin
                    cmd.out_load         = 1'b1;
                    cmd.out_sel          = OUT_PEND;
                    cmd.out_last         = 1'b0;
                    cmd.anchor_from_pend = 1'b1;
                    state_next           = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_reg) begin
                    if (out_free) begin
                        cmd.out_load    = 1'b1;
                        cmd.out_sel     = OUT_NEW;
                        cmd.out_last    = 1'b1;
                        started_next    = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.pend_from_new = 1'b1;
                    pend_valid_next   = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    a_pend_needs_path: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> started_reg)
        else $error("pending point held outside a started path");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start processing");

    a_run_from_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_RUN) |-> ($past(state_reg) == ST_DIFF && step_reg == '0))
        else $error("program started without loading differences");

endmodule

/* src/pps_datapath.sv */
// Datapath of the polyline simplifier: point registers, differences, one shared
// multiplier with accumulators, configuration registers and output register.
// Depends on pps_pkg; steered by pps_ctrl through ctl_cmd_t.
module pps_datapath #(
    parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pps_pkg::ctl_cmd_t                   cmd,
    output logic                                keep,
    input  logic signed [COORD_WIDTH-1:0]       s_coord_x,
    input  logic signed [COORD_WIDTH-1:0]       s_coord_y,
    input  logic signed [COORD_WIDTH-1:0]       s_coord_z,
    input  logic                                cfg_valid,
    input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [COORD_WIDTH-1:0]       m_out_x,
    output logic signed [COORD_WIDTH-1:0]       m_out_y,
    output logic signed [COORD_WIDTH-1:0]       m_out_z,
    output logic                                m_end_of_path
);
    import pps_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int MW  = (W + 1 > TOL_W) ? W + 1 : TOL_W;
    localparam int AW  = 4 * MW;
    localparam int XW  = 2 * W + 2;
    localparam int CMW = 2 * W + 1;
    localparam int BBW = 2 * W + 2;
    localparam int CCW = 4 * W + 4;
    localparam int TBW = 2 * W + 25;
    localparam int RHW = 2 * W + 48;

    logic signed [W-1:0] new_reg  [3];
    logic signed [W-1:0] pend_reg [3];
    logic signed [W-1:0] anc_reg  [3];
    logic [W-1:0]        a_mag_reg [3];
    logic [W-1:0]        b_mag_reg [3];
    logic                a_neg_reg [3];
    logic                b_neg_reg [3];

    logic [TOL_W-1:0]    tol_reg;
    logic [DEG_SQ_W-1:0] deg_sq_reg;

    logic [2*MW-1:0]       prod_reg;
    logic                  prod_neg_reg;
    dst_t                  dst_reg;
    shift_t                sh_reg;
    logic [BBW-1:0]        bb_reg;
    logic signed [XW-1:0]  cross_reg;
    logic [CCW-1:0]        cc_reg;
    logic [TBW-1:0]        tb_reg;
    logic [RHW-1:0]        rhs_reg;

    logic signed [W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                out_last_reg;

    logic signed [W:0]   da [3];
    logic signed [W:0]   db [3];
    logic [W:0]          da_abs [3];
    logic [W:0]          db_abs [3];

    logic [XW-1:0]       cabs;
    logic [AW-1:0]       cmag_ext, bb_ext, tb_ext, prod_ext, term;
    logic [MW-1:0]       op_a, op_b;
    logic                sgn_a, sgn_b;
    logic signed [XW-1:0] xt, xs;

    // Differences to the anchor, split into magnitude and sign
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            da[k]     = {pend_reg[k][W-1], pend_reg[k]} - {anc_reg[k][W-1], anc_reg[k]};
            db[k]     = {new_reg[k][W-1], new_reg[k]} - {anc_reg[k][W-1], anc_reg[k]};
            da_abs[k] = da[k][W] ? -da[k] : da[k];
            db_abs[k] = db[k][W] ? -db[k] : db[k];
        end
    end

    assign cabs     = cross_reg[XW-1] ? -cross_reg : cross_reg;
    assign cmag_ext = AW'(cabs[CMW-1:0]);
    assign bb_ext   = AW'(bb_reg);
    assign tb_ext   = AW'(tb_reg);

    always_comb begin
        op_a  = '0;
        sgn_a = 1'b0;
        case (cmd.step.src_a)
            SRC_A0:  begin op_a = MW'(a_mag_reg[0]); sgn_a = a_neg_reg[0]; end
            SRC_A1:  begin op_a = MW'(a_mag_reg[1]); sgn_a = a_neg_reg[1]; end
            SRC_A2:  begin op_a = MW'(a_mag_reg[2]); sgn_a = a_neg_reg[2]; end
            SRC_B0:  begin op_a = MW'(b_mag_reg[0]); sgn_a = b_neg_reg[0]; end
            SRC_B1:  begin op_a = MW'(b_mag_reg[1]); sgn_a = b_neg_reg[1]; end
            SRC_B2:  begin op_a = MW'(b_mag_reg[2]); sgn_a = b_neg_reg[2]; end
            SRC_CLO: op_a = cmag_ext[MW-1:0];
            SRC_CHI: op_a = cmag_ext[2*MW-1:MW];
            SRC_TOL: op_a = MW'(tol_reg);
            SRC_BB0: op_a = bb_ext[MW-1:0];
            SRC_BB1: op_a = bb_ext[2*MW-1:MW];
            SRC_TB0: op_a = tb_ext[MW-1:0];
            SRC_TB1: op_a = tb_ext[2*MW-1:MW];
            SRC_TB2: op_a = tb_ext[3*MW-1:2*MW];
            default: op_a = '0;
        endcase
    end

    always_comb begin
        op_b  = '0;
        sgn_b = 1'b0;
        case (cmd.step.src_b)
            SRC_A0:  begin op_b = MW'(a_mag_reg[0]); sgn_b = a_neg_reg[0]; end
            SRC_A1:  begin op_b = MW'(a_mag_reg[1]); sgn_b = a_neg_reg[1]; end
            SRC_A2:  begin op_b = MW'(a_mag_reg[2]); sgn_b = a_neg_reg[2]; end
            SRC_B0:  begin op_b = MW'(b_mag_reg[0]); sgn_b = b_neg_reg[0]; end
            SRC_B1:  begin op_b = MW'(b_mag_reg[1]); sgn_b = b_neg_reg[1]; end
            SRC_B2:  begin op_b = MW'(b_mag_reg[2]); sgn_b = b_neg_reg[2]; end
            SRC_CLO: op_b = cmag_ext[MW-1:0];
            SRC_CHI: op_b = cmag_ext[2*MW-1:MW];
            SRC_TOL: op_b = MW'(tol_reg);
            SRC_BB0: op_b = bb_ext[MW-1:0];
            SRC_BB1: op_b = bb_ext[2*MW-1:MW];
            SRC_TB0: op_b = tb_ext[MW-1:0];
            SRC_TB1: op_b = tb_ext[2*MW-1:MW];
            SRC_TB2: op_b = tb_ext[3*MW-1:2*MW];
            default: op_b = '0;
        endcase
    end

    // Align the registered product for its accumulator
    assign prod_ext = AW'(prod_reg);
    always_comb begin
        case (sh_reg)
            SH_0:    term = prod_ext;
            SH_1:    term = prod_ext << MW;
            SH_1P:   term = prod_ext << (MW + 1);
            SH_2:    term = prod_ext << (2 * MW);
            default: term = prod_ext;
        endcase
    end

    assign xt = signed'(XW'(prod_reg));
    assign xs = prod_neg_reg ? -xt : xt;

    assign keep = (bb_ext < AW'(deg_sq_reg)) || (AW'(cc_reg) > AW'(rhs_reg));

    // Multiplier stage and pipelined accumulate control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_reg <= DST_NONE;
            sh_reg  <= SH_0;
        end else begin
            dst_reg <= cmd.step.dst;
            sh_reg  <= cmd.step.sh;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= op_a * op_b;
        prod_neg_reg <= sgn_a ^ sgn_b;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_diff) begin
            bb_reg  <= '0;
            cc_reg  <= '0;
            tb_reg  <= '0;
            rhs_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                a_mag_reg[k] <= da_abs[k][W-1:0];
                a_neg_reg[k] <= da[k][W];
                b_mag_reg[k] <= db_abs[k][W-1:0];
                b_neg_reg[k] <= db[k][W];
            end
        end else begin
            case (dst_reg)
                DST_BB:   bb_reg    <= bb_reg + term[BBW-1:0];
                DST_XNEW: cross_reg <= xs;
                DST_XSUB: cross_reg <= cross_reg - xs;
                DST_CC:   cc_reg    <= cc_reg + term[CCW-1:0];
                DST_TB:   tb_reg    <= tb_reg + term[TBW-1:0];
                DST_RHS:  rhs_reg   <= rhs_reg + term[RHW-1:0];
                default:  ;
            endcase
        end
    end

    // Point registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            new_reg[0] <= s_coord_x;
            new_reg[1] <= s_coord_y;
            new_reg[2] <= s_coord_z;
        end
        if (cmd.pend_from_new) begin
            pend_reg <= new_reg;
        end
        if (cmd.anchor_from_new) begin
            anc_reg <= new_reg;
        end else if (cmd.anchor_from_pend) begin
            anc_reg <= pend_reg;
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_sel == OUT_PEND) begin
                out_x_reg <= pend_reg[0];
                out_y_reg <= pend_reg[1];
                out_z_reg <= pend_reg[2];
            end else begin
                out_x_reg <= new_reg[0];
                out_y_reg <= new_reg[1];
                out_z_reg <= new_reg[2];
            end
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_out_z       = out_z_reg;
    assign m_end_of_path = out_last_reg;

    // Configuration registers; the degenerate length is kept squared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= TOL_RESET;
            deg_sq_reg <= DEG_SQ_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_TOLERANCE: tol_reg    <= cfg_data[TOL_W-1:0];
                CFG_DEGEN_LEN: deg_sq_reg <= cfg_data[DEG_W-1:0] * cfg_data[DEG_W-1:0];
                default:       ;
            endcase
        end
    end

    a_clear_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_diff |-> (dst_reg == DST_NONE))
        else $error("accumulators cleared while a product was landing");

endmodule

/* src/polyline_perpendicular_simplifier_unit.sv */
// Top level of the streaming 3D polyline simplifier by perpendicular distance.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_coord_x/y/z, s_final_point
//  m_      | out       | m_valid / m_ready    | m_out_x/y/z, m_end_of_path
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One waypoint word at a time. The first word of a path runs the start state,
// a word with no pending point the final update; a word that tests a pending
// point runs difference load, 23 steps of the single shared multiplier, flush,
// decision and the final update. Output waits add cycles when m_ready is low.
// Reset (synchronous, aresetn low) clears the path and restores the registers.
module polyline_perpendicular_simplifier_unit #(
    parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_WIDTH-1:0]   s_coord_x,
    input  logic signed [COORD_WIDTH-1:0]   s_coord_y,
    input  logic signed [COORD_WIDTH-1:0]   s_coord_z,
    input  logic                            s_final_point,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [COORD_WIDTH-1:0]   m_out_x,
    output logic signed [COORD_WIDTH-1:0]   m_out_y,
    output logic signed [COORD_WIDTH-1:0]   m_out_z,
    output logic                            m_end_of_path,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pps_pkg::*;

    ctl_cmd_t cmd;
    logic     keep;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_final_point (s_final_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .keep          (keep),
        .cmd           (cmd)
    );

    pps_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .keep          (keep),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_end_of_path (m_end_of_path)
    );

endmodule

/* tb/sv/polyline_perpendicular_simplifier_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for polyline_perpendicular_simplifier_unit: directed rows, then
// random paths under several register settings, checked against an in-bench predictor.
// Depends on pps_pkg and the RTL of the block.
module polyline_perpendicular_simplifier_unit_test;
    import pps_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int MAXC      = (1 << (CW - 1)) - 1;
    localparam int MINC      = -(1 << (CW - 1));
    localparam int SETTLE    = 40;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 80;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } waypoint_t;

    typedef struct packed {
        waypoint_t pt;
        logic      last;
    } kept_point_t;

    typedef enum {
        ROW_POINT,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        waypoint_t        pt;
        logic             fin;
        int               typed_n;
        logic             typed_last;
        cfg_reg_t         reg_idx;
        logic [CFG_DATA_W-1:0] value;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_coord_x = '0;
    coord_t s_coord_y = '0;
    coord_t s_coord_z = '0;
    logic s_final_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    coord_t m_out_x;
    coord_t m_out_y;
    coord_t m_out_z;
    logic m_end_of_path;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and register copies
    logic [TOL_W-1:0] tol_reg = TOL_W'(2048);
    logic [DEG_W-1:0] degen_len_reg = DEG_W'(4);
    waypoint_t anchor = '0;
    waypoint_t held_point = '0;
    logic held_valid = 1'b0;
    logic path_open = 1'b0;

    kept_point_t kept_points_q[$];
    kept_point_t want_point;
    int mismatches = 0;
    int points_accepted = 0;
    int rx_hold_left = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;
    stim_row_t directed_rows[$];

    polyline_perpendicular_simplifier_unit #(.COORD_WIDTH(CW)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .s_coord_z    (s_coord_z),
        .s_final_point(s_final_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_z      (m_out_z),
        .m_end_of_path(m_end_of_path),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // append to the tail of the stimulus table and of the expected-word queue
    function automatic void add_row(stim_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_kept(kept_point_t k);
        kept_points_q = {kept_points_q, k};
    endfunction

    // Exact integer form of the distance test: |a x b|^2 > tol^2 * |b|^2, or |b|^2 below the degenerate length squared
    function automatic bit pending_is_kept(waypoint_t anc, waypoint_t mid, waypoint_t nxt);
        logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz, bb, cc, lim, tol_w;
        ax = $signed(mid.x) - $signed(anc.x);
        ay = $signed(mid.y) - $signed(anc.y);
        az = $signed(mid.z) - $signed(anc.z);
        bx = $signed(nxt.x) - $signed(anc.x);
        by = $signed(nxt.y) - $signed(anc.y);
        bz = $signed(nxt.z) - $signed(anc.z);
        bb = bx * bx + by * by + bz * bz;
        lim = degen_len_reg * degen_len_reg;
        if (bb < lim) begin
            return 1'b1;
        end
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        cc = cx * cx + cy * cy + cz * cz;
        tol_w = tol_reg;
        return cc > tol_w * tol_w * bb;
    endfunction

    // Advance the path state by one waypoint; n is the number of kept points emitted.
    task automatic advance_path(input waypoint_t p, input logic fin, output int n,
                                output kept_point_t r0, output kept_point_t r1);
        n = 0;
        r0 = '0;
        r1 = '0;
        if (!path_open) begin
            r0.pt = p;
            r0.last = fin;
            n = 1;
            if (!fin) begin
                anchor = p;
                path_open = 1'b1;
                held_valid = 1'b0;
            end
        end else begin
            if (held_valid && pending_is_kept(anchor, held_point, p)) begin
                r0.pt = held_point;
                r0.last = 1'b0;
                n = 1;
                anchor = held_point;
            end
            if (fin) begin
                if (n == 0) begin
                    r0.pt = p;
                    r0.last = 1'b1;
                end else begin
                    r1.pt = p;
                    r1.last = 1'b1;
                end
                n++;
                path_open = 1'b0;
                held_valid = 1'b0;
            end else begin
                held_point = p;
                held_valid = 1'b1;
            end
        end
    endtask

    // Call at a rising edge; returns at the edge that accepts the word (or after a gap).
    task automatic send_point(input waypoint_t p, input logic fin, input int typed_n,
                              input logic typed_last);
        int n;
        kept_point_t r0, r1;
        s_valid <= 1'b1;
        s_coord_x <= p.x;
        s_coord_y <= p.y;
        s_coord_z <= p.z;
        s_final_point <= fin;
        do @(posedge aclk); while (!s_ready);
        points_accepted++;
        advance_path(p, fin, n, r0, r1);
        if (typed_n >= 0) begin
            n = typed_n;
            r0.pt = p;
            r0.last = typed_last;
        end
        if (n > 0) add_kept(r0);
        if (n > 1) add_kept(r1);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Hold the sender until every kept point is out and the block has settled.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (kept_points_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Returns after the write, with the channel idle again.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TOLERANCE: tol_reg = value[TOL_W-1:0];
            CFG_DEGEN_LEN: degen_len_reg = value[DEG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic stim_row_t point_row(int x, int y, int z, logic fin, int typed_n,
                                            logic typed_last);
        stim_row_t r;
        r.kind = ROW_POINT;
        r.pt.x = coord_t'(x);
        r.pt.y = coord_t'(y);
        r.pt.z = coord_t'(z);
        r.fin = fin;
        r.typed_n = typed_n;
        r.typed_last = typed_last;
        r.reg_idx = CFG_TOLERANCE;
        r.value = '0;
        return r;
    endfunction

    function automatic stim_row_t write_row(cfg_reg_t idx, int value);
        stim_row_t r;
        r = point_row(0, 0, 0, 1'b0, -1, 1'b0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.value = CFG_DATA_W'(value);
        return r;
    endfunction

    function automatic int spread(int s);
        return int'($urandom_range(0, (2 << s) - 1)) - (1 << s);
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (kept_points_q.size() == 0) begin
                report_mismatch("unexpected word, x", m_out_x, 0);
            end else begin
                want_point = kept_points_q.pop_front();
                if (m_out_x !== want_point.pt.x) report_mismatch("out_x", m_out_x, want_point.pt.x);
                if (m_out_y !== want_point.pt.y) report_mismatch("out_y", m_out_y, want_point.pt.y);
                if (m_out_z !== want_point.pt.z) report_mismatch("out_z", m_out_z, want_point.pt.z);
                if (m_end_of_path !== want_point.last)
                    report_mismatch("end_of_path", m_end_of_path, want_point.last);
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            rx_hold_left <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("polyline_perpendicular_simplifier_unit_test NOT OK");
        $finish;
    end

    initial begin
        int phase, target, len, k, s, js, bx, by, bz, dx, dy, dz, wait_cycles;
        int unsigned tol_pick, deg_pick;
        waypoint_t pt;
        logic fin;
        stim_row_t row;

        // reset state, first point, two-point and single-point paths at the extremes
        add_row(point_row(0, 0, 0, 1'b0, 1, 1'b0));
        add_row(point_row(MAXC, MAXC, MAXC, 1'b1, 1, 1'b1));
        add_row(point_row(MINC, MINC, MINC, 1'b1, 1, 1'b1));
        add_row(point_row(MINC, MAXC, 0, 1'b0, 1, 1'b0));
        add_row(point_row(MAXC, MINC, MAXC, 1'b0, 0, 1'b0));
        add_row(point_row(MAXC, MAXC, MINC, 1'b0, -1, 1'b0));
        add_row(point_row(0, MINC, MAXC, 1'b1, -1, 1'b0));
        // collinear middle point dropped, then kept point followed by the final one
        add_row(point_row(0, 0, 0, 1'b0, 1, 1'b0));
        add_row(point_row(4096, 0, 0, 1'b0, 0, 1'b0));
        add_row(point_row(8192, 0, 0, 1'b0, -1, 1'b0));
        add_row(point_row(8192, 100000, 0, 1'b1, -1, 1'b0));
        // short segment forces a keep; then register changes in the middle of a path
        add_row(point_row(1000, 1000, 1000, 1'b0, 1, 1'b0));
        add_row(point_row(1003, 1000, 1000, 1'b0, 0, 1'b0));
        add_row(point_row(1001, 1000, 1000, 1'b0, -1, 1'b0));
        add_row(write_row(CFG_DEGEN_LEN, 0));
        add_row(point_row(1003, 1000, 1000, 1'b0, -1, 1'b0));
        add_row(write_row(CFG_TOLERANCE, 0));
        add_row(point_row(1500, 1001, 1000, 1'b0, -1, 1'b0));
        add_row(point_row(2003, 1000, 1000, 1'b1, -1, 1'b0));
        // largest tolerance; length written with bits above its width set
        add_row(write_row(CFG_TOLERANCE, MAXC));
        add_row(write_row(CFG_DEGEN_LEN, (1 << CFG_DATA_W) - 1));
        add_row(point_row(0, 0, 0, 1'b0, 1, 1'b0));
        add_row(point_row(MAXC, 0, 0, 1'b0, 0, 1'b0));
        add_row(point_row(MINC, MAXC, MINC, 1'b1, -1, 1'b0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                wait_for_idle();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_point(row.pt, row.fin, row.typed_n, row.typed_last);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_idle();
            case (phase)
                0: begin tol_pick = 2048; deg_pick = 4; end
                1: begin tol_pick = 0; deg_pick = 0; end
                2: begin tol_pick = MAXC; deg_pick = (1 << DEG_W) - 1; end
                3: begin
                    tol_pick = $urandom_range(0, 1 << 16);
                    deg_pick = $urandom_range(0, 64);
                end
                4: begin tol_pick = $urandom; deg_pick = $urandom; end
                default: begin
                    tol_pick = $urandom_range(0, 20000);
                    deg_pick = $urandom_range(0, 16);
                end
            endcase
            write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol_pick));
            write_reg(CFG_DEGEN_LEN, CFG_DATA_W'(deg_pick));
            tx_gaps_on = (phase != 1) && (phase != PHASES - 1);
            rx_stalls_on = tx_gaps_on;
            target = points_accepted + PER_PHASE;
            while (points_accepted < target) begin
                if ($urandom_range(0, 9) < 2) begin
                    // noise: any coordinates, final now and then
                    pt.x = coord_t'($urandom);
                    pt.y = coord_t'($urandom);
                    pt.z = coord_t'($urandom);
                    fin = ($urandom_range(0, 2) == 0);
                    send_point(pt, fin, -1, 1'b0);
                end else begin
                    // a path along a random direction with jitter of random size
                    len = $urandom_range(1, 10);
                    s = $urandom_range(1, 21);
                    js = $urandom_range(0, s);
                    bx = int'(coord_t'($urandom));
                    by = int'(coord_t'($urandom));
                    bz = int'(coord_t'($urandom));
                    dx = spread(s);
                    dy = spread(s);
                    dz = spread(s);
                    for (k = 0; k < len; k++) begin
                        pt.x = coord_t'(bx + k * dx + spread(js));
                        pt.y = coord_t'(by + k * dy + spread(js));
                        pt.z = coord_t'(bz + k * dz + spread(js));
                        send_point(pt, k == len - 1, -1, 1'b0);
                    end
                end
            end
        end

        s_valid <= 1'b0;
        wait_cycles = 0;
        while (kept_points_q.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (kept_points_q.size() != 0) begin
            report_mismatch("kept points never emitted", 0, kept_points_q.size());
        end
        if (mismatches == 0) begin
            $display("polyline_perpendicular_simplifier_unit_test OK");
        end else begin
            $display("polyline_perpendicular_simplifier_unit_test NOT OK");
        end
        $finish;
    end

endmodule
